/* rtl/core/tcc_pkg.sv */
package tcc_pkg;

  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int CELL_W    = CHAR_W + COLOR_W;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
  localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_COLOR, SPACE_CODE};

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wen;
    logic ren;
  } mem_ctl_t;

endpackage

/* rtl/core/tcc_if.sv */
interface tcc_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [tcc_pkg::CMD_W-1:0]      command;
  logic [tcc_pkg::CHAR_W-1:0]     char_code;
  logic [tcc_pkg::ROW_OUT_W-1:0]  read_row;
  logic [tcc_pkg::COL_OUT_W-1:0]  read_column;

  modport source(output valid, command, char_code, read_row, read_column, input ready);
  modport sink(input valid, command, char_code, read_row, read_column, output ready);
endinterface

interface tcc_res_if;
  logic                           valid;
  logic                           ready;
  logic [tcc_pkg::ROW_OUT_W-1:0]  cursor_row_out;
  logic [tcc_pkg::COL_OUT_W-1:0]  cursor_column_out;
  logic [tcc_pkg::CELL_W-1:0]     cell_value;

  modport source(output valid, cursor_row_out, cursor_column_out, cell_value, input ready);
  modport sink(input valid, cursor_row_out, cursor_column_out, cell_value, output ready);
endinterface

/* rtl/core/tcc_screen_mem.sv */
module tcc_screen_mem #(
  parameter int DEPTH = 2000,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  tcc_pkg::mem_ctl_t           ctl,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [tcc_pkg::CELL_W-1:0]  wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [tcc_pkg::CELL_W-1:0]  rdata
);

  logic [tcc_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/tcc_ctrl.sv */
module tcc_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int CELLS = ROWS * COLUMNS,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [tcc_pkg::COLOR_W-1:0]  cfg_wdata,
  tcc_cmd_if.sink                      cmd,
  tcc_res_if.source                    res,
  output tcc_pkg::mem_ctl_t            mem_ctl,
  output logic [ADDR_W-1:0]            mem_waddr,
  output logic [tcc_pkg::CELL_W-1:0]   mem_wdata,
  output logic [ADDR_W-1:0]            mem_raddr,
  input  logic [tcc_pkg::CELL_W-1:0]   mem_rdata
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam logic [ADDR_W-1:0] CELL_LAST     = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(ROWS - 1);

  tcc_pkg::state_t state, state_next;

  logic [ROW_W-1:0]            cursor_row;
  logic [COL_W-1:0]            cursor_col;
  logic [ADDR_W-1:0]           cursor_addr;
  logic [tcc_pkg::COLOR_W-1:0] text_color;
  logic [ADDR_W-1:0]           cnt;
  logic                        cp_valid;
  logic [ADDR_W-1:0]           cp_addr;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        cell_hit;
  logic                        out_valid;
  logic [tcc_pkg::ROW_OUT_W-1:0] out_row;
  logic [tcc_pkg::COL_OUT_W-1:0] out_col;
  logic [tcc_pkg::CELL_W-1:0]  out_cell;

  logic              is_newline;
  logic              is_put;
  logic              advance_row;
  logic              at_last_row;
  logic              cnt_last;
  logic              read_ok;
  logic              out_free;
  logic [ADDR_W-1:0] read_addr_calc;

  assign is_newline  = cmd.char_code == tcc_pkg::NEWLINE_CODE;
  assign is_put      = cmd.command == tcc_pkg::CMD_PUT;
  assign advance_row = is_newline || (cursor_col == COL_LAST);
  assign at_last_row = cursor_row == ROW_LAST;
  assign cnt_last    = cnt == CELL_LAST;
  assign read_ok     = (32'(cmd.read_row) < ROWS) && (32'(cmd.read_column) < COLUMNS);
  assign read_addr_calc = ADDR_W'(32'(cmd.read_row) * COLUMNS + 32'(cmd.read_column));
  assign out_free    = !out_valid || res.ready;

  always_comb begin
    state_next = state;
    case (state)
      tcc_pkg::ST_INIT:   if (cnt_last) state_next = tcc_pkg::ST_IDLE;
      tcc_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.command)
            tcc_pkg::CMD_PUT:
              state_next = (advance_row && at_last_row) ? tcc_pkg::ST_SCROLL : tcc_pkg::ST_DONE;
            tcc_pkg::CMD_CLEAR: state_next = tcc_pkg::ST_FILL;
            tcc_pkg::CMD_READ:  state_next = read_ok ? tcc_pkg::ST_READ : tcc_pkg::ST_DONE;
            default:            state_next = tcc_pkg::ST_DONE;
          endcase
        end
      end
      tcc_pkg::ST_READ:   state_next = tcc_pkg::ST_DONE;
      tcc_pkg::ST_SCROLL: if (cnt_last) state_next = tcc_pkg::ST_DRAIN;
      tcc_pkg::ST_DRAIN:  state_next = tcc_pkg::ST_FILL;
      tcc_pkg::ST_FILL:   if (cnt_last) state_next = tcc_pkg::ST_DONE;
      tcc_pkg::ST_DONE:   if (out_free) state_next = tcc_pkg::ST_IDLE;
      default:            state_next = tcc_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd.ready   = 1'b0;
    mem_ctl.wen = 1'b0;
    mem_ctl.ren = 1'b0;
    mem_waddr   = cursor_addr;
    mem_wdata   = {text_color, cmd.char_code};
    mem_raddr   = cnt;
    case (state)
      tcc_pkg::ST_INIT: begin
        mem_ctl.wen = 1'b1;
        mem_waddr   = cnt;
        mem_wdata   = tcc_pkg::RESET_CELL;
      end
      tcc_pkg::ST_IDLE: begin
        cmd.ready   = 1'b1;
        mem_ctl.wen = cmd.valid && is_put && !is_newline;
      end
      tcc_pkg::ST_READ: begin
        mem_ctl.ren = 1'b1;
        mem_raddr   = rd_addr;
      end
      tcc_pkg::ST_SCROLL, tcc_pkg::ST_DRAIN: begin
        mem_ctl.ren = state == tcc_pkg::ST_SCROLL;
        mem_ctl.wen = cp_valid;
        mem_waddr   = cp_addr;
        mem_wdata   = mem_rdata;
      end
      tcc_pkg::ST_FILL: begin
        mem_ctl.wen = 1'b1;
        mem_waddr   = cnt;
        mem_wdata   = {text_color, tcc_pkg::SPACE_CODE};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tcc_pkg::ST_INIT;
      cnt         <= '0;
      cursor_row  <= '0;
      cursor_col  <= '0;
      cursor_addr <= '0;
      text_color  <= tcc_pkg::RESET_COLOR;
      cp_valid    <= 1'b0;
      cell_hit    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      cp_valid <= state == tcc_pkg::ST_SCROLL;
      if (cfg_wen) begin
        text_color <= cfg_wdata;
      end
      case (state)
        tcc_pkg::ST_INIT, tcc_pkg::ST_SCROLL, tcc_pkg::ST_FILL: cnt <= cnt + 1'b1;
        tcc_pkg::ST_DRAIN: cnt <= LAST_ROW_BASE;
        tcc_pkg::ST_IDLE: begin
          if (cmd.valid) begin
            cell_hit <= 1'b0;
            case (cmd.command)
              tcc_pkg::CMD_PUT: begin
                if (advance_row) begin
                  cursor_col <= '0;
                  if (at_last_row) begin
                    cursor_addr <= LAST_ROW_BASE;
                    cnt         <= ROW_STRIDE;
                  end else begin
                    cursor_row  <= cursor_row + 1'b1;
                    cursor_addr <= cursor_addr + ROW_STRIDE - ADDR_W'(cursor_col);
                  end
                end else begin
                  cursor_col  <= cursor_col + 1'b1;
                  cursor_addr <= cursor_addr + 1'b1;
                end
              end
              tcc_pkg::CMD_CLEAR: begin
                cnt         <= '0;
                cursor_row  <= '0;
                cursor_col  <= '0;
                cursor_addr <= '0;
              end
              tcc_pkg::CMD_READ: cell_hit <= read_ok;
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
      if (state == tcc_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cp_addr <= cnt - ROW_STRIDE;
    if (state == tcc_pkg::ST_IDLE) begin
      rd_addr <= read_addr_calc;
    end
    if (state == tcc_pkg::ST_DONE && out_free) begin
      out_row  <= tcc_pkg::ROW_OUT_W'(cursor_row);
      out_col  <= tcc_pkg::COL_OUT_W'(cursor_col);
      out_cell <= cell_hit ? mem_rdata : '0;
    end
  end

  assign res.valid             = out_valid;
  assign res.cursor_row_out    = out_row;
  assign res.cursor_column_out = out_col;
  assign res.cell_value        = out_cell;

endmodule

/* rtl/core/text_console_cursor_scroll.sv */
// Text console: screen store of ROWS x COLUMNS cells (colour high byte, character
// low byte) plus a cursor.
// cmd channel (valid/ready): command, char_code, read_row, read_column.
// res channel (valid/ready): one result per command with the cursor after the
// command and, for an in-range read, the cell; cell_value is 0 otherwise.
// cfg_wen/cfg_wdata write text_color, the attribute for new cells; write only
// while the block is idle.
// res valid is set from the done state; put character or newline without a scroll
// and unused codes reach it straight from idle, an in-range read via the read state.
// Clear sweeps the store one cell a cycle through the single write port.
// Leaving the last row scrolls: one read and one write of the store per cycle
// copy each row up, then the bottom row is blanked. One command is in progress
// at a time; a new one is taken as soon as its predecessor's result sits in the
// output register.
// After reset the store is filled with grey blanks, with cmd ready low; text_color
// resets to 7 and the cursor to the top left.
// A stalled res holds its result; the block then waits with ready low.
module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [tcc_pkg::COLOR_W-1:0]  cfg_wdata,
  tcc_cmd_if.sink                      cmd,
  tcc_res_if.source                    res
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  tcc_pkg::mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [tcc_pkg::CELL_W-1:0] mem_wdata;
  logic [tcc_pkg::CELL_W-1:0] mem_rdata;

  tcc_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd),
    .res(res),
    .mem_ctl(mem_ctl),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  tcc_screen_mem #(
    .DEPTH(CELLS)
  ) u_mem (
    .clk(clk),
    .ctl(mem_ctl),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

/* rtl/core/tcc_checker.sv */
module tcc_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tcc_pkg::ROW_OUT_W-1:0]   out_row,
  input logic [tcc_pkg::COL_OUT_W-1:0]   out_col,
  input logic [tcc_pkg::CELL_W-1:0]      out_cell
);

  a_reset_sweep: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("cmd ready high straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) && $stable(out_cell))
    else $error("stalled result changed");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_col) < COLUMNS)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_row) < ROWS)
    else $error("cursor row out of range");

endmodule

bind text_console_cursor_scroll tcc_checker #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_tcc_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(cmd.ready),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .out_row(res.cursor_row_out),
  .out_col(res.cursor_column_out),
  .out_cell(res.cell_value)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLS;
  localparam logic [tcc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct packed {
    logic [tcc_pkg::CMD_W-1:0]     command;
    logic [tcc_pkg::CHAR_W-1:0]    char_code;
    logic [tcc_pkg::ROW_OUT_W-1:0] read_row;
    logic [tcc_pkg::COL_OUT_W-1:0] read_column;
  } console_cmd_t;

  typedef struct packed {
    logic [tcc_pkg::ROW_OUT_W-1:0] row;
    logic [tcc_pkg::COL_OUT_W-1:0] col;
    logic [tcc_pkg::CELL_W-1:0]    cell_val;
  } cursor_cell_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen;
  logic [tcc_pkg::COLOR_W-1:0] cfg_wdata;

  tcc_cmd_if cmd_bus();
  tcc_res_if res_bus();

  text_console_cursor_scroll #(.COLUMNS(COLS), .ROWS(ROWS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd_bus),
    .res      (res_bus)
  );

  always #6 clk = ~clk;

  // shadow of the console
  logic [tcc_pkg::CELL_W-1:0]  shadow_cells [0:CELLS-1];
  int unsigned                 shadow_row;
  int unsigned                 shadow_col;
  logic [tcc_pkg::COLOR_W-1:0] shadow_color;

  console_cmd_t cmd_pending [$];
  cursor_cell_t cursor_cell_queue [$];
  console_cmd_t cmd_on_bus;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen;
  int unsigned hold_left;
  int unsigned errors = 0;
  int unsigned quiet_cycles;

  function automatic void advance_row();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++)
        shadow_cells[i] = {shadow_color, tcc_pkg::SPACE_CODE};
      shadow_row = ROWS - 1;
    end
  endfunction

  function automatic cursor_cell_t apply_console_cmd(console_cmd_t c);
    cursor_cell_t r;
    r.cell_val = '0;
    case (c.command)
      tcc_pkg::CMD_PUT: begin
        if (c.char_code == tcc_pkg::NEWLINE_CODE) begin
          advance_row();
        end else begin
          shadow_cells[shadow_row * COLS + shadow_col] = {shadow_color, c.char_code};
          shadow_col++;
          if (shadow_col >= COLS) advance_row();
        end
      end
      tcc_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_color, tcc_pkg::SPACE_CODE};
        shadow_row = 0;
        shadow_col = 0;
      end
      tcc_pkg::CMD_READ: begin
        if (c.read_row < ROWS && c.read_column < COLS)
          r.cell_val = shadow_cells[c.read_row * COLS + c.read_column];
      end
      default: ;
    endcase
    r.row = shadow_row[tcc_pkg::ROW_OUT_W-1:0];
    r.col = shadow_col[tcc_pkg::COL_OUT_W-1:0];
    return r;
  endfunction

  // in queue_put and queue_read, fields a command ignores get random values
  task automatic queue_cmd(logic [tcc_pkg::CMD_W-1:0] command,
                           logic [tcc_pkg::CHAR_W-1:0] ch,
                           logic [tcc_pkg::ROW_OUT_W-1:0] rr,
                           logic [tcc_pkg::COL_OUT_W-1:0] rc);
    console_cmd_t c;
    c.command = command;
    c.char_code = ch;
    c.read_row = rr;
    c.read_column = rc;
    cmd_pending.push_back(c);
  endtask

  task automatic queue_put(logic [tcc_pkg::CHAR_W-1:0] ch);
    queue_cmd(tcc_pkg::CMD_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  task automatic queue_read(logic [tcc_pkg::ROW_OUT_W-1:0] rr,
                            logic [tcc_pkg::COL_OUT_W-1:0] rc);
    queue_cmd(tcc_pkg::CMD_READ, 8'($urandom_range(0, 255)), rr, rc);
  endtask

  task automatic queue_random_text(int unsigned target);
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    n = 0;
    while (n < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = $urandom_range(1, 12);
        repeat (len) queue_put(8'($urandom_range(0, 255)));
        n += len;
      end else if (kind < 56) begin
        queue_put(tcc_pkg::NEWLINE_CODE);
        n++;
      end else if (kind < 80) begin
        if ($urandom_range(0, 9) == 0)
          queue_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
        else if ($urandom_range(0, 1) == 0)
          queue_read(5'($urandom_range(ROWS - 5, ROWS - 1)), 7'($urandom_range(0, COLS - 1)));
        else
          queue_read(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLS - 1)));
        n++;
      end else if (kind < 82) begin
        len = $urandom_range(8, 26);
        repeat (len) queue_put(tcc_pkg::NEWLINE_CODE);
        n += len;
      end else if (kind < 84) begin
        len = $urandom_range(60, 170);
        repeat (len) queue_put(8'($urandom_range(0, 255)));
        n += len;
      end else if (kind < 85) begin
        queue_cmd(tcc_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                  7'($urandom_range(0, 127)));
        n++;
      end else if (kind < 88) begin
        queue_cmd(CMD_UNUSED, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                  7'($urandom_range(0, 127)));
        n++;
      end else begin
        queue_put(8'($urandom_range(0, 255)));
        n++;
      end
    end
  endtask

  task automatic wait_console_idle();
    do @(posedge clk);
    while (cmd_pending.size() != 0 || cmd_bus.valid || cursor_cell_queue.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_text_color(logic [tcc_pkg::COLOR_W-1:0] color);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= color;
    shadow_color = color;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // command driver
  always @(posedge clk) begin : drive_cmd
    console_cmd_t nxt;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready)
        cursor_cell_queue.push_back(apply_console_cmd(cmd_on_bus));
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (cmd_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = cmd_pending.pop_front();
          cmd_on_bus <= nxt;
          cmd_bus.valid <= 1'b1;
          cmd_bus.command <= nxt.command;
          cmd_bus.char_code <= nxt.char_code;
          cmd_bus.read_row <= nxt.read_row;
          cmd_bus.read_column <= nxt.read_column;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with the long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      res_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin : check_res
    cursor_cell_t want;
    cursor_cell_t got;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got.row = res_bus.cursor_row_out;
      got.col = res_bus.cursor_column_out;
      got.cell_val = res_bus.cell_value;
      if (cursor_cell_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer: expected none, got row %0d col %0d cell %h",
                 $time, got.row, got.col, got.cell_val);
      end else begin
        want = cursor_cell_queue.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.cell_val !== want.cell_val) begin
          errors++;
          $display("%0t: expected row %0d col %0d cell %h, got row %0d col %0d cell %h",
                   $time, want.row, want.col, want.cell_val, got.row, got.col, got.cell_val);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               cursor_cell_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [tcc_pkg::COLOR_W-1:0] colors [PHASES];
    colors = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h07, 8'h1E, 8'h00, 8'h00};
    colors[6] = 8'($urandom_range(0, 255));
    colors[7] = 8'($urandom_range(0, 255));
    cmd_bus.valid = 1'b0;
    cmd_bus.command = tcc_pkg::CMD_PUT;
    cmd_bus.char_code = '0;
    cmd_bus.read_row = '0;
    cmd_bus.read_column = '0;
    res_bus.ready = 1'b0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = tcc_pkg::RESET_CELL;
    shadow_row = 0;
    shadow_col = 0;
    shadow_color = tcc_pkg::RESET_COLOR;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, range edges, unused code, newline, clear
    @(negedge clk);
    queue_read(5'd0, 7'd0);
    queue_read(5'(ROWS - 1), 7'(COLS - 1));
    queue_read(5'(ROWS), 7'd0);
    queue_read(5'd0, 7'(COLS));
    queue_read(5'h1F, 7'h7F);
    queue_put(8'h48);
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(8'h80);
    queue_read(5'd0, 7'd0);
    queue_read(5'd0, 7'd1);
    queue_read(5'd0, 7'd2);
    queue_read(5'd0, 7'd3);
    queue_cmd(CMD_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    queue_cmd(CMD_UNUSED, 8'h00, 5'h00, 7'h00);
    queue_put(tcc_pkg::NEWLINE_CODE);
    queue_put(8'h7F);
    queue_read(5'd1, 7'd0);
    queue_cmd(tcc_pkg::CMD_CLEAR, 8'hFF, 5'h1F, 7'h7F);
    queue_read(5'd0, 7'd0);
    queue_put(8'h01);
    queue_read(5'd0, 7'd0);
    wait_console_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_text_color(colors[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      @(negedge clk);
      if (ph == 1) begin
        // walk to the bottom, scroll, then wrap a full line and scroll again
        repeat (ROWS + 1) queue_put(tcc_pkg::NEWLINE_CODE);
        queue_read(5'(ROWS - 1), 7'd0);
        queue_read(5'(ROWS - 2), 7'(COLS - 1));
        repeat (COLS + 5) queue_put(8'($urandom_range(0, 255)));
        queue_read(5'(ROWS - 2), 7'(COLS - 1));
        queue_read(5'(ROWS - 1), 7'd4);
        queue_read(5'(ROWS - 1), 7'(COLS - 1));
      end
      queue_random_text(ITEMS_PER_PHASE);
      if (ph == 0 || ph == 4) hold_req = ~hold_req;
      wait_console_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tcc_pkg.sv
rtl/core/tcc_if.sv
rtl/core/tcc_screen_mem.sv
rtl/core/tcc_ctrl.sv
rtl/core/text_console_cursor_scroll.sv
rtl/core/tcc_checker.sv
bench/tb_top.sv
